[rtl/pcse_pkg.sv]
// Shared types and constants of the piecewise cubic spline evaluator.
`default_nettype none
package pcse_pkg;

  localparam int QW     = 32;
  localparam int USED_W = 4;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_EVAL   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0] cubic;
    logic signed [QW-1:0] square;
    logic signed [QW-1:0] linear;
    logic signed [QW-1:0] konst;
    logic signed [QW-1:0] end_pos;
  } seg_t;

  typedef struct packed {
    logic                 done;
    logic                 sat;
    logic signed [QW-1:0] value;
  } mac_res_t;

endpackage
`default_nettype wire

[rtl/pcse_seg_mem.sv]
// Segment table memory: one write port, one registered read port.
`default_nettype none
module pcse_seg_mem #(
  parameter int SEGMENTS = 16,
  localparam int IdxW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire pcse_pkg::seg_t  wdata,
  input  wire logic [IdxW-1:0] raddr,
  output pcse_pkg::seg_t       rdata
);

  pcse_pkg::seg_t mem [SEGMENTS];
  pcse_pkg::seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/pcse_mac.sv]
// Shared Horner step unit: registered multiply, then floor shift, add and clip.
`default_nettype none
module pcse_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic signed [pcse_pkg::QW-1:0] mul_a,
  input  wire logic signed [pcse_pkg::QW-1:0] mul_b,
  input  wire logic signed [pcse_pkg::QW-1:0] coef,
  output pcse_pkg::mac_res_t               res
);

  localparam int PW = 2 * pcse_pkg::QW;

  logic                           prod_vld_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [pcse_pkg::QW-1:0] coef_r;

  logic signed [PW-1:0]           shifted_c;
  logic signed [PW:0]             sum_c;
  logic                           ovf_c;
  logic signed [pcse_pkg::QW-1:0] clip_c;

  pcse_pkg::mac_res_t res_r;
  pcse_pkg::mac_res_t res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
      coef_r <= coef;
    end
  end

  // An arithmetic shift rounds toward minus infinity.
  always_comb begin
    shifted_c = prod_r >>> FRAC_BITS;
    sum_c     = {shifted_c[PW-1], shifted_c} + (PW+1)'(coef_r);
    ovf_c     = (sum_c[PW:pcse_pkg::QW-1] != {(PW-pcse_pkg::QW+2){1'b0}}) &&
                (sum_c[PW:pcse_pkg::QW-1] != {(PW-pcse_pkg::QW+2){1'b1}});
    if (!ovf_c) begin
      clip_c = sum_c[pcse_pkg::QW-1:0];
    end else if (sum_c[PW]) begin
      clip_c = pcse_pkg::Q_MIN;
    end else begin
      clip_c = pcse_pkg::Q_MAX;
    end
    res_nxt.done  = prod_vld_r;
    res_nxt.sat   = ovf_c;
    res_nxt.value = clip_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[rtl/piecewise_cubic_spline_evaluator_unit.sv]
// Top level of the piecewise cubic spline evaluator: sequencer and result registers.
//
//   Channel  Handshake            Payload
//   in       start / busy         in_opcode, in_coef_*, in_segment_end, in_position
//   out      out_valid (strobe)   out_value, out_segment_used, out_beyond_end,
//                                 out_error, out_saturated
//
// Append, clear, an unused opcode and evaluate on an empty table never raise busy;
// their result is strobed in the cycle after the item is accepted.
// An evaluate that picks segment k keeps busy high while the segment search reads
// the stored ends up to segment k, one per cycle, from the single table read port,
// then while three Horner steps run on the shared multiplier. The result is
// strobed in the cycle busy falls. Reset clears the segment count; the table needs
// no clearing. The receiver cannot stall, so results are never held.
`default_nettype none
module piecewise_cubic_spline_evaluator_unit #(
  parameter int SEGMENTS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_coef_cubic,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_coef_square,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_coef_linear,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_coef_const,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_segment_end,
  input  wire logic signed [pcse_pkg::QW-1:0]    in_position,
  output      logic                              out_valid,
  output      logic signed [pcse_pkg::QW-1:0]    out_value,
  output      logic [pcse_pkg::USED_W-1:0]       out_segment_used,
  output      logic                              out_beyond_end,
  output      logic                              out_error,
  output      logic                              out_saturated
);

  localparam int CNT_W = $clog2(SEGMENTS + 1);
  localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int QW    = pcse_pkg::QW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SRCH   = 3'd1;
  localparam logic [2:0] ST_LAST   = 3'd2;
  localparam logic [2:0] ST_BEYOND = 3'd3;
  localparam logic [2:0] ST_LOADC  = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_MWAIT  = 3'd6;

  localparam logic [1:0] STEP_SQ    = 2'd0;
  localparam logic [1:0] STEP_LIN   = 2'd1;
  localparam logic [1:0] STEP_CONST = 2'd2;

  logic [2:0]             state_r,     state_nxt;
  logic [CNT_W-1:0]       cnt_r,       cnt_nxt;
  logic [IDX_W-1:0]       i_r,         i_nxt;
  logic [IDX_W-1:0]       idx_r,       idx_nxt;
  logic signed [QW-1:0]   s_r,         s_nxt;
  logic signed [QW-1:0]   lo_r,        lo_nxt;
  logic signed [QW-1:0]   ss_r,        ss_nxt;
  logic signed [QW-1:0]   acc_r,       acc_nxt;
  logic [1:0]             step_r,      step_nxt;
  logic                   sat_r,       sat_nxt;
  logic                   beyond_r,    beyond_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [QW-1:0]   out_value_r, out_value_nxt;
  logic [pcse_pkg::USED_W-1:0] out_used_r, out_used_nxt;
  logic                   out_beyond_r, out_beyond_nxt;
  logic                   out_error_r,  out_error_nxt;
  logic                   out_sat_r,    out_sat_nxt;

  logic                   accept_c;
  logic                   full_c;
  logic                   last_c;
  logic                   hit_c;
  logic signed [QW:0]     diff_c;
  logic                   diff_ovf_c;
  logic signed [QW-1:0]   diff_clip_c;
  logic [IDX_W-1:0]       rd_addr_c;
  logic                   mem_we_c;
  logic signed [QW-1:0]   coef_c;
  logic                   mac_go_c;

  pcse_pkg::seg_t         wr_seg_c;
  pcse_pkg::seg_t         rd_seg;
  pcse_pkg::mac_res_t     mac_res;

  assign accept_c = start && !busy;
  assign full_c   = (cnt_r == CNT_W'(SEGMENTS));
  assign last_c   = ((CNT_W'(i_r) + CNT_W'(1)) == cnt_r);
  assign mem_we_c = accept_c && (in_opcode == pcse_pkg::OP_APPEND) && !full_c;

  assign wr_seg_c.cubic   = in_coef_cubic;
  assign wr_seg_c.square  = in_coef_square;
  assign wr_seg_c.linear  = in_coef_linear;
  assign wr_seg_c.konst   = in_coef_const;
  assign wr_seg_c.end_pos = in_segment_end;

  pcse_seg_mem #(
    .SEGMENTS (SEGMENTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we_c),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wr_seg_c),
    .raddr (rd_addr_c),
    .rdata (rd_seg)
  );

  always_comb begin
    unique case (step_r)
      STEP_SQ:  coef_c = rd_seg.square;
      STEP_LIN: coef_c = rd_seg.linear;
      default:  coef_c = rd_seg.konst;
    endcase
  end

  pcse_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mac_go_c),
    .mul_a (acc_r),
    .mul_b (ss_r),
    .coef  (coef_c),
    .res   (mac_res)
  );

  // Offset into the chosen segment, clipped to the Q range.
  always_comb begin
    diff_c     = {s_r[QW-1], s_r} - {lo_r[QW-1], lo_r};
    diff_ovf_c = (diff_c[QW] != diff_c[QW-1]);
    if (!diff_ovf_c) begin
      diff_clip_c = diff_c[QW-1:0];
    end else if (diff_c[QW]) begin
      diff_clip_c = pcse_pkg::Q_MIN;
    end else begin
      diff_clip_c = pcse_pkg::Q_MAX;
    end
    hit_c = ((s_r >= lo_r) && (s_r <= rd_seg.end_pos)) || last_c;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    idx_nxt        = idx_r;
    s_nxt          = s_r;
    lo_nxt         = lo_r;
    ss_nxt         = ss_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    sat_nxt        = sat_r;
    beyond_nxt     = beyond_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_used_nxt   = out_used_r;
    out_beyond_nxt = out_beyond_r;
    out_error_nxt  = out_error_r;
    out_sat_nxt    = out_sat_r;
    rd_addr_c      = idx_r;
    mac_go_c       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Address 0 is read while idle so the first stored end is ready at once.
        rd_addr_c = '0;
        if (accept_c) begin
          out_value_nxt  = '0;
          out_used_nxt   = '0;
          out_beyond_nxt = 1'b0;
          out_error_nxt  = 1'b0;
          out_sat_nxt    = 1'b0;
          unique case (in_opcode)
            pcse_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              out_error_nxt = full_c;
              if (!full_c) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            pcse_pkg::OP_EVAL: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_error_nxt = 1'b1;
              end else begin
                s_nxt     = in_position;
                lo_nxt    = '0;
                i_nxt     = '0;
                sat_nxt   = 1'b0;
                state_nxt = ST_SRCH;
              end
            end
            pcse_pkg::OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              cnt_nxt       = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SRCH: begin
        rd_addr_c = i_r + IDX_W'(1);
        if (hit_c) begin
          idx_nxt   = i_r;
          ss_nxt    = diff_clip_c;
          sat_nxt   = diff_ovf_c;
          state_nxt = ST_LAST;
        end else begin
          lo_nxt = rd_seg.end_pos;
          i_nxt  = i_r + IDX_W'(1);
        end
      end
      ST_LAST: begin
        rd_addr_c = IDX_W'(cnt_r - CNT_W'(1));
        state_nxt = ST_BEYOND;
      end
      ST_BEYOND: begin
        beyond_nxt = (s_r > rd_seg.end_pos);
        state_nxt  = ST_LOADC;
      end
      ST_LOADC: begin
        acc_nxt   = rd_seg.cubic;
        step_nxt  = STEP_SQ;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mac_go_c  = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mac_res.done) begin
          acc_nxt = mac_res.value;
          sat_nxt = sat_r | mac_res.sat;
          if (step_r == STEP_CONST) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = mac_res.value;
            out_used_nxt   = pcse_pkg::USED_W'(idx_r);
            out_beyond_nxt = beyond_r;
            out_error_nxt  = 1'b0;
            out_sat_nxt    = sat_r | mac_res.sat;
            state_nxt      = ST_IDLE;
          end else begin
            step_nxt  = step_r + 2'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    idx_r        <= idx_nxt;
    s_r          <= s_nxt;
    lo_r         <= lo_nxt;
    ss_r         <= ss_nxt;
    acc_r        <= acc_nxt;
    step_r       <= step_nxt;
    sat_r        <= sat_nxt;
    beyond_r     <= beyond_nxt;
    out_value_r  <= out_value_nxt;
    out_used_r   <= out_used_nxt;
    out_beyond_r <= out_beyond_nxt;
    out_error_r  <= out_error_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_segment_used = out_used_r;
  assign out_beyond_end   = out_beyond_r;
  assign out_error        = out_error_r;
  assign out_saturated    = out_sat_r;

  // A result is only ever strobed while no evaluation is in flight.
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SEGMENTS))
    else $error("segment count beyond table depth");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_c && (in_opcode == pcse_pkg::OP_EVAL) && (cnt_r != '0)) |=> busy)
    else $error("evaluate on a filled table did not start the sequencer");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> ((out_value == '0) && !out_saturated && !out_beyond_end))
    else $error("error result carries a value");

  a_mac_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res.done |-> (state_r == ST_MWAIT))
    else $error("multiplier result outside its wait state");

endmodule
`default_nettype wire
